### hdl/rar_pkg.sv
// rar_pkg: shared types and constants for the rational arithmetic unit
// no dependencies
package rar_pkg;
  localparam int OPERAND_BITS_DEF = 16;
  localparam int RES_NUM_BITS = 33;
  localparam int RES_DEN_BITS = 31;
  localparam int OP_BITS = 3;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] ORD_LESS = 2'd0;
  localparam logic [1:0] ORD_EQUAL = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_SUM, ST_GCD, ST_DIVN, ST_DIVD, ST_OUT
  } state_t;
endpackage

### hdl/rational_arith_reduce_unit.sv
// rational_arith_reduce_unit: add/sub/mul/div/compare of two fractions,
// result reduced to lowest terms by a shared sequential remainder unit
// depends on rar_pkg
//
// usage: one item on s_axis (operation and four operands) gives one result
// item on m_axis. s_axis_tready is high only while the unit is idle.
// the item is normalized, then two products (three for add and subtract)
// are formed one per cycle on one shared multiplier. the gcd of numerator
// and denominator magnitude is found by euclid steps, each remainder taken
// by a restoring divider at one quotient bit per cycle; the two exact
// divisions by the gcd use the same divider. compare and zero results
// skip the gcd and the divisions, and fault and unused operation codes
// go straight to the output register.
// the result sits in an output register until m_axis_tready; a new item
// is taken in the cycle after it is delivered, so receiver stalls hold the unit.
// rst returns the sequencer to idle and drops m_axis_tvalid.
module rational_arith_reduce_unit #(
  parameter int OPERAND_BITS = rar_pkg::OPERAND_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // operation, a_num, a_den, b_num, b_den (lowest first), zero padded
  input  logic [((rar_pkg::OP_BITS + 4*OPERAND_BITS + 7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // res_num, res_den, order, fault (lowest first), zero padded
  output logic [71:0] m_axis_tdata
);
  localparam int W = OPERAND_BITS;
  localparam int PW = 2*W + 1;   // magnitude width of products and sums
  localparam int CW = $clog2(PW);
  localparam int NUM_W = rar_pkg::RES_NUM_BITS;
  localparam int DEN_W = rar_pkg::RES_DEN_BITS;
  localparam int OPW = rar_pkg::OP_BITS;

  rar_pkg::state_t state, state_next;

  logic [OPW-1:0] op;
  logic signed [W:0] an, ad, bn, bd;   // normalized, one extra bit
  logic signed [2*W+1:0] p0, p1, p2;   // products
  logic nneg;
  logic [PW-1:0] nmag, dmag;
  // divider
  logic [PW-1:0] dv_q, dv_r, dv_d;
  logic [CW-1:0] cnt;
  logic signed [NUM_W-1:0] o_num;
  logic [DEN_W-1:0] o_den;
  logic [1:0] o_ord;
  logic o_fault;

  logic [OPW-1:0] in_op;
  logic signed [W-1:0] in_an, in_ad, in_bn, in_bd;
  logic in_fault;
  assign in_op = s_axis_tdata[OPW-1:0];
  assign in_an = s_axis_tdata[OPW +: W];
  assign in_ad = s_axis_tdata[OPW+W +: W];
  assign in_bn = s_axis_tdata[OPW+2*W +: W];
  assign in_bd = s_axis_tdata[OPW+3*W +: W];
  assign in_fault = (in_ad == '0) || (in_bd == '0) ||
                    (in_op == rar_pkg::OP_DIV && in_bn == '0);

  // shared multiplier operands
  logic signed [W:0] mx, my;
  logic signed [2*W+1:0] mprod;
  always_comb begin
    case (state)
      rar_pkg::ST_MUL0: begin
        mx = an;
        my = (op == rar_pkg::OP_MUL) ? bn : bd;
      end
      rar_pkg::ST_MUL1: begin
        mx = ad;
        my = (op == rar_pkg::OP_MUL) ? bd : bn;
      end
      default: begin
        mx = ad;
        my = bd;
      end
    endcase
  end
  assign mprod = mx * my;

  // numerator and denominator before reduction
  logic signed [2*W+2:0] sum;
  logic nneg_val, num_zero;
  logic [PW-1:0] nmag_val, dmag_val;
  logic [1:0] cmp_ord;
  assign sum = (op == rar_pkg::OP_ADD) ? (2*W+3)'(p0) + (2*W+3)'(p1)
                                       : (2*W+3)'(p0) - (2*W+3)'(p1);
  always_comb begin
    if (op == rar_pkg::OP_ADD || op == rar_pkg::OP_SUB) begin
      nneg_val = (sum < 0);
      nmag_val = PW'(sum < 0 ? -sum : sum);
      dmag_val = PW'(p2);
      num_zero = (sum == '0);
    end else begin
      // products carry the signs; p1 is the denominator
      nneg_val = (p0 < 0) != (p1 < 0);
      nmag_val = PW'(p0 < 0 ? -p0 : p0);
      dmag_val = PW'(p1 < 0 ? -p1 : p1);
      num_zero = (p0 == '0);
    end
  end
  assign cmp_ord = (p0 < p1) ? rar_pkg::ORD_LESS :
                   (p0 == p1) ? rar_pkg::ORD_EQUAL : rar_pkg::ORD_GREATER;

  // restoring divider step
  logic [PW:0] shr;
  logic [PW+1:0] trial;
  logic [PW-1:0] rem_next, quo_next;
  logic step_last;
  always_comb begin
    shr = {dv_r, dv_q[PW-1]};
    trial = {1'b0, shr} - {2'b00, dv_d};
    rem_next = trial[PW+1] ? shr[PW-1:0] : trial[PW-1:0];
    quo_next = {dv_q[PW-2:0], ~trial[PW+1]};
  end
  assign step_last = (cnt == CW'(PW-1));

  always_comb begin
    state_next = state;
    case (state)
      rar_pkg::ST_IDLE: if (s_axis_tvalid) begin
        if (in_op > rar_pkg::OP_CMP || in_fault) state_next = rar_pkg::ST_OUT;
        else state_next = rar_pkg::ST_MUL0;
      end
      rar_pkg::ST_MUL0: state_next = rar_pkg::ST_MUL1;
      rar_pkg::ST_MUL1: begin
        if (op == rar_pkg::OP_ADD || op == rar_pkg::OP_SUB) state_next = rar_pkg::ST_MUL2;
        else state_next = rar_pkg::ST_SUM;
      end
      rar_pkg::ST_MUL2: state_next = rar_pkg::ST_SUM;
      rar_pkg::ST_SUM: begin
        if (op == rar_pkg::OP_CMP || num_zero) state_next = rar_pkg::ST_OUT;
        else state_next = rar_pkg::ST_GCD;
      end
      rar_pkg::ST_GCD: if (step_last && rem_next == '0) state_next = rar_pkg::ST_DIVN;
      rar_pkg::ST_DIVN: if (step_last) state_next = rar_pkg::ST_DIVD;
      rar_pkg::ST_DIVD: if (step_last) state_next = rar_pkg::ST_OUT;
      rar_pkg::ST_OUT: if (m_axis_tready) state_next = rar_pkg::ST_IDLE;
      default: state_next = rar_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == rar_pkg::ST_IDLE);
    m_axis_tvalid = (state == rar_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rar_pkg::ST_IDLE;
    end else begin
      state <= state_next;
      case (state)
        rar_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            op <= in_op;
            an <= (in_ad < 0) ? -(W+1)'(in_an) : (W+1)'(in_an);
            ad <= (in_ad < 0) ? -(W+1)'(in_ad) : (W+1)'(in_ad);
            bn <= (in_bd < 0) ? -(W+1)'(in_bn) : (W+1)'(in_bn);
            bd <= (in_bd < 0) ? -(W+1)'(in_bd) : (W+1)'(in_bd);
            o_num <= '0;
            o_den <= (in_op <= rar_pkg::OP_CMP && in_fault) ? '0 : DEN_W'(1);
            o_ord <= rar_pkg::ORD_LESS;
            o_fault <= (in_op <= rar_pkg::OP_CMP) && in_fault;
          end
        end
        rar_pkg::ST_MUL0: p0 <= mprod;
        rar_pkg::ST_MUL1: p1 <= mprod;
        rar_pkg::ST_MUL2: p2 <= mprod;
        rar_pkg::ST_SUM: begin
          o_ord <= (op == rar_pkg::OP_CMP) ? cmp_ord : rar_pkg::ORD_LESS;
          nneg <= nneg_val;
          nmag <= nmag_val;
          dmag <= dmag_val;
          dv_q <= nmag_val;
          dv_d <= dmag_val;
          dv_r <= '0;
          cnt <= '0;
        end
        rar_pkg::ST_GCD: begin
          if (step_last) begin
            cnt <= '0;
            dv_r <= '0;
            if (rem_next == '0) begin
              // dv_d now holds the gcd
              dv_q <= nmag;
            end else begin
              dv_q <= dv_d;
              dv_d <= rem_next;
            end
          end else begin
            cnt <= cnt + CW'(1);
            dv_r <= rem_next;
            dv_q <= quo_next;
          end
        end
        rar_pkg::ST_DIVN: begin
          if (step_last) begin
            nmag <= quo_next;
            dv_q <= dmag;
            dv_r <= '0;
            cnt <= '0;
          end else begin
            cnt <= cnt + CW'(1);
            dv_r <= rem_next;
            dv_q <= quo_next;
          end
        end
        rar_pkg::ST_DIVD: begin
          if (step_last) begin
            o_den <= DEN_W'(quo_next);
            o_num <= nneg ? -NUM_W'(nmag) : NUM_W'(nmag);
          end else begin
            cnt <= cnt + CW'(1);
            dv_r <= rem_next;
            dv_q <= quo_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tdata = {5'd0, o_fault, o_ord, o_den, o_num};

`ifndef NO_ASSERTIONS
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid));
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid);
  a_fault_den: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[66] |-> m_axis_tdata[63:33] == '0);
`endif
endmodule

### tb/sv/rational_arith_reduce_unit_test.sv
// rational_arith_reduce_unit_test: self-checking bench for the fraction arithmetic unit
// drives random and corner-case operand items and compares each result against
// an internal predictor; depends on rar_pkg and rational_arith_reduce_unit
`timescale 1ns / 100ps

class fraction_scoreboard;
  logic [71:0] pending_results[$];
  int mismatch_count;
  int reported;

  function logic [71:0] reduce_fraction(logic [2:0] op, logic signed [15:0] an_in,
                                        logic signed [15:0] ad_in,
                                        logic signed [15:0] bn_in,
                                        logic signed [15:0] bd_in);
    longint an, ad, bn, bd, l, r, s, n, d, x, y, t;
    bit neg;
    logic [32:0] rn;
    logic [30:0] rd;
    logic [1:0] ord;
    an = an_in; ad = ad_in; bn = bn_in; bd = bd_in;
    ord = rar_pkg::ORD_LESS;
    if (op > rar_pkg::OP_CMP) return {5'd0, 1'b0, 2'd0, 31'd1, 33'd0};
    if (ad == 0 || bd == 0) return {5'd0, 1'b1, 2'd0, 31'd0, 33'd0};
    if (ad < 0) begin ad = -ad; an = -an; end
    if (bd < 0) begin bd = -bd; bn = -bn; end
    l = an * bd;
    r = bn * ad;
    case (op)
      rar_pkg::OP_CMP: begin
        ord = (l < r) ? rar_pkg::ORD_LESS :
              (l == r) ? rar_pkg::ORD_EQUAL : rar_pkg::ORD_GREATER;
        return {5'd0, 1'b0, ord, 31'd1, 33'd0};
      end
      rar_pkg::OP_ADD: begin s = l + r; d = ad * bd; end
      rar_pkg::OP_SUB: begin s = l - r; d = ad * bd; end
      rar_pkg::OP_MUL: begin s = an * bn; d = ad * bd; end
      default: begin
        if (bn == 0) return {5'd0, 1'b1, 2'd0, 31'd0, 33'd0};
        s = an * bd;
        d = ad * bn;
        if (d < 0) begin d = -d; s = -s; end
      end
    endcase
    if (s == 0) return {5'd0, 1'b0, 2'd0, 31'd1, 33'd0};
    neg = s < 0;
    n = neg ? -s : s;
    x = n; y = d;
    while (y != 0) begin t = x % y; x = y; y = t; end
    n = n / x;
    d = d / x;
    rn = 33'(neg ? -n : n);
    rd = 31'(d);
    return {5'd0, 1'b0, 2'd0, rd, rn};
  endfunction

  function void note_item(logic [71:0] item);
    pending_results.push_back(reduce_fraction(item[2:0], item[18:3], item[34:19],
                                              item[50:35], item[66:51]));
  endfunction

  function void check_result(logic [71:0] got);
    logic [71:0] want;
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (reported < 10) begin
        reported++;
        $display("unexpected result %h", got);
      end
      return;
    end
    want = pending_results.pop_front();
    if (got[32:0] !== want[32:0] || got[63:33] !== want[63:33] ||
        got[65:64] !== want[65:64] || got[66] !== want[66] || got[71:67] !== 5'd0) begin
      mismatch_count++;
      if (reported < 10) begin
        reported++;
        $display("mismatch: num exp %0d got %0d, den exp %0d got %0d,",
                 $signed(want[32:0]), $signed(got[32:0]), want[63:33], got[63:33],
                 " order exp %0d got %0d, fault exp %0d got %0d",
                 want[65:64], got[65:64], want[66], got[66]);
      end
    end
  endfunction
endclass

module rational_arith_reduce_unit_test;
  localparam longint CYCLE_LIMIT = 10000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // operation, a_num, a_den, b_num, b_den (lowest first), zero padded
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // res_num, res_den, order, fault (lowest first), zero padded
  logic [71:0] m_axis_tdata;

  fraction_scoreboard board = new();
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_off = 1'b0;
  longint cycle_count = 0;

  rational_arith_reduce_unit DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[rational_arith_reduce_unit] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    m_axis_tready <= !rst && !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // tvalid stays high after an accept until the next idle or the end of the run
  task automatic send_item(logic [2:0] op, logic [15:0] an, logic [15:0] ad,
                           logic [15:0] bn, logic [15:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, bd, bn, ad, an, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_item({5'd0, bd, bn, ad, an, op});
  endtask

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(5))
      0: return 16'(16'h8000 + $urandom_range(2));
      1: return 16'(16'h7fff - $urandom_range(2));
      2: return 16'($urandom_range(6) - 3);
      3: return 16'($urandom_range(40) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_items(int count);
    logic [2:0] op;
    repeat (count) begin
      op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
      send_item(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
  endtask

  initial begin
    int k;
    send_idle_pct = 17;
    recv_idle_pct = 87;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // extremes, every operation, zero denominators, divide by zero, unused codes
    send_item(rar_pkg::OP_ADD, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    send_item(rar_pkg::OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_item(rar_pkg::OP_MUL, 16'h8000, 16'hffff, 16'h8000, 16'hffff);
    send_item(rar_pkg::OP_DIV, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    send_item(rar_pkg::OP_CMP, 16'd1, 16'd2, 16'd2, 16'd4);
    send_item(rar_pkg::OP_CMP, 16'hffff, 16'd2, 16'd1, 16'd2);
    send_item(rar_pkg::OP_CMP, 16'd3, 16'd2, 16'd1, 16'hfffe);
    send_item(rar_pkg::OP_ADD, 16'd1, 16'd0, 16'd1, 16'd1);
    send_item(rar_pkg::OP_CMP, 16'd1, 16'd1, 16'd1, 16'd0);
    send_item(rar_pkg::OP_DIV, 16'd5, 16'd3, 16'd0, 16'd7);
    send_item(rar_pkg::OP_SUB, 16'd3, 16'd4, 16'd6, 16'd8);
    send_item(rar_pkg::OP_MUL, 16'd0, 16'hffff, 16'd9, 16'd2);
    send_item(rar_pkg::OP_DIV, 16'd6, 16'hfffc, 16'hfffd, 16'd2);
    for (k = 5; k < 8; k++) send_item(3'(k), 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_item(rar_pkg::OP_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    random_items(220);
    // long receiver hold-off while the sender keeps offering
    hold_off <= 1'b1;
    fork
      begin repeat (400) @(posedge clk); hold_off <= 1'b0; end
      random_items(6);
    join
    send_idle_pct = 87;
    recv_idle_pct = 17;
    random_items(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(320);
    s_axis_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.mismatch_count == 0 && board.pending_results.size() == 0)
      $display("[rational_arith_reduce_unit] OK");
    else
      $display("[rational_arith_reduce_unit] ERROR");
    $finish;
  end
endmodule

### files.f
hdl/rar_pkg.sv
hdl/rational_arith_reduce_unit.sv
tb/sv/rational_arith_reduce_unit_test.sv
